// ===== src/lsmb_pkg.sv =====
// shared constants, types and helper functions of the lidar sector minimum binner
package lsmb_pkg;

   localparam int SECTOR_COUNT = 72;
   localparam int SAMPLE_BITS  = 16;
   localparam int MAX_RESULTS  = 36;

   localparam int RANGE_W  = 16;
   localparam int COUNT_W  = 12;
   localparam int SECTOR_W = 7;
   localparam int CM_W     = 16;
   localparam int CSR_IDX_W = 2;
   localparam int PER_W    = COUNT_W + 1;
   localparam int FLUSH_W  = $clog2(SECTOR_COUNT + MAX_RESULTS);

   localparam logic [RANGE_W-1:0]  SAMPLE_MASK = RANGE_W'((64'd1 << SAMPLE_BITS) - 64'd1);
   localparam logic [SECTOR_W-1:0] LAST_SECTOR = SECTOR_W'(SECTOR_COUNT - 1);

   // reciprocal of the sector count for the per-sector length
   localparam int RECIP_SHIFT = 24;
   localparam longint unsigned RECIP =
      ((64'd1 << RECIP_SHIFT) + SECTOR_COUNT - 1) / SECTOR_COUNT;

   localparam logic [RANGE_W-1:0] MIN_RANGE_RST   = 16'd38;
   localparam logic [RANGE_W-1:0] MAX_RANGE_RST   = 16'd3072;
   localparam logic [COUNT_W-1:0] SCAN_POINTS_RST = 12'd1440;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MIN_RANGE   = 2'd0,
      CSR_MAX_RANGE   = 2'd1,
      CSR_SCAN_POINTS = 2'd2
   } csr_reg_type;

   typedef struct packed {
      logic [SECTOR_W-1:0] sector_index;
      logic [CM_W-1:0]     distance_cm;
      logic                last_sector;
   } result_type;

   // q8.8 metres to centimetres, at most 25599 so no saturation is needed
   function automatic logic [CM_W-1:0] to_cm(input logic [RANGE_W-1:0] q);
      logic [RANGE_W+6:0] prod;
      prod = (RANGE_W+7)'(q) * (RANGE_W+7)'(100);
      return CM_W'(prod >> 8);
   endfunction

   function automatic logic [CM_W-1:0] empty_cm_of(input logic [RANGE_W-1:0] max_range);
      return to_cm(max_range) + CM_W'(1);
   endfunction

   function automatic logic [COUNT_W-1:0] points_of(input logic [COUNT_W-1:0] scan_points);
      return (scan_points < COUNT_W'(SECTOR_COUNT)) ? COUNT_W'(SECTOR_COUNT) : scan_points;
   endfunction

   // ceil(points / SECTOR_COUNT) by reciprocal multiply
   function automatic logic [PER_W-1:0] per_sector_of(input logic [COUNT_W-1:0] scan_points);
      logic [PER_W-1:0] x;
      logic [39:0]      prod;
      x    = PER_W'(points_of(scan_points)) + PER_W'(SECTOR_COUNT - 1);
      prod = 40'(x) * 40'(RECIP);
      return PER_W'(prod >> RECIP_SHIFT);
   endfunction

endpackage

// ===== src/lsmb_req_if.sv =====
// input channel carrying one range sample per item
interface lsmb_req_if import lsmb_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [RANGE_W-1:0] range_sample;

   modport source (output valid, output range_sample, input ready);
   modport sink (input valid, input range_sample, output ready);
endinterface

// ===== src/lsmb_rsp_if.sv =====
// result channel carrying one sector distance per item
interface lsmb_rsp_if import lsmb_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [SECTOR_W-1:0] sector_index;
   logic [CM_W-1:0]     distance_cm;
   logic                last_sector;

   modport source (output valid, output sector_index, output distance_cm,
                   output last_sector, input ready);
   modport sink (input valid, input sector_index, input distance_cm,
                 input last_sector, output ready);
endinterface

// ===== src/lsmb_csr_if.sv =====
// register write channel
interface lsmb_csr_if import lsmb_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [RANGE_W-1:0]   data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

// ===== src/lidar_sector_min_binner_top.sv =====
// Lidar sector minimum binner: takes one range sample per cycle, keeps the
// closest in-range sample of each angular sector and emits one centimetre
// distance per sector. Samples are accepted one per cycle unless a flush runs
// or the queue is full; the compare, the sector counting and the conversion
// to centimetres sit between the input handshake and a two-entry result queue,
// so an item that closes a sector is queued as it is accepted. The sample that
// ends a scan queues the open sector and starts a flush sequencer that emits
// the later sectors, one per cycle while the queue has room, up to 36 results
// in all; no sample is taken until the flush has been queued. A sample is
// accepted while one result waits. Register writes are taken in any cycle.
module lidar_sector_min_binner_top import lsmb_pkg::*; (
   input logic         clock,
   input logic         reset,
   lsmb_req_if.sink    req_ch,
   lsmb_rsp_if.source  rsp_ch,
   lsmb_csr_if.sink    csr_ch
);

   // configuration and values derived from it at write time
   logic [RANGE_W-1:0]  min_range_ff;
   logic [RANGE_W-1:0]  max_range_ff;
   logic [COUNT_W-1:0]  points_ff;
   logic [PER_W-1:0]    per_sector_ff;
   logic [CM_W-1:0]     empty_cm_ff;

   // scan state
   logic [COUNT_W-1:0]  sample_in_sector_ff;
   logic [COUNT_W-1:0]  sample_in_scan_ff;
   logic [SECTOR_W-1:0] current_sector_ff;
   logic [RANGE_W-1:0]  sector_minimum_ff;
   logic                minimum_found_ff;

   // flush sequencer
   logic                flush_active_ff;
   logic [SECTOR_W-1:0] flush_sector_ff;
   logic [SECTOR_W-1:0] flush_end_ff;

   // result queue
   result_type          queue_ff [2];
   logic                wr_ptr_ff;
   logic                rd_ptr_ff;
   logic [1:0]          count_ff;

   logic                csr_write;
   logic                accept;
   logic [RANGE_W-1:0]  sample;
   logic                take;
   logic [RANGE_W-1:0]  minimum_in;
   logic                found_in;
   logic [PER_W-1:0]    scan_next;
   logic [PER_W-1:0]    sec_count;
   logic                scan_end;
   logic                sector_done;
   logic [FLUSH_W-1:0]  flush_sum;
   logic [SECTOR_W-1:0] flush_end_in;
   logic                queue_full;
   logic                pop;
   logic                item_push;
   logic                flush_push;
   logic                push;
   result_type          push_data;

   assign csr_ch.ready = 1'b1;
   assign csr_write    = csr_ch.valid && csr_ch.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_range_ff  <= MIN_RANGE_RST;
         max_range_ff  <= MAX_RANGE_RST;
         empty_cm_ff   <= empty_cm_of(MAX_RANGE_RST);
         points_ff     <= points_of(SCAN_POINTS_RST);
         per_sector_ff <= per_sector_of(SCAN_POINTS_RST);
      end else if (csr_write) begin
         case (csr_reg_type'(csr_ch.index))
            CSR_MIN_RANGE: begin
               min_range_ff <= csr_ch.data;
            end
            CSR_MAX_RANGE: begin
               max_range_ff <= csr_ch.data;
               empty_cm_ff  <= empty_cm_of(csr_ch.data);
            end
            CSR_SCAN_POINTS: begin
               points_ff     <= points_of(csr_ch.data[COUNT_W-1:0]);
               per_sector_ff <= per_sector_of(csr_ch.data[COUNT_W-1:0]);
            end
            default: begin
            end
         endcase
      end
   end

   assign queue_full    = (count_ff == 2'd2);
   assign pop           = rsp_ch.valid && rsp_ch.ready;
   assign req_ch.ready  = !flush_active_ff && !queue_full;
   assign accept        = req_ch.valid && req_ch.ready;

   always_comb begin
      sample      = req_ch.range_sample & SAMPLE_MASK;
      take        = (sample > min_range_ff) && (sample < max_range_ff) &&
                    (!minimum_found_ff || (sample < sector_minimum_ff));
      minimum_in  = take ? sample : sector_minimum_ff;
      found_in    = take || minimum_found_ff;
      scan_next   = PER_W'(sample_in_scan_ff) + PER_W'(1);
      sec_count   = PER_W'(sample_in_sector_ff) + PER_W'(1);
      scan_end    = (scan_next >= PER_W'(points_ff));
      sector_done = (sec_count >= per_sector_ff) && (current_sector_ff != LAST_SECTOR);
      // flush covers at most MAX_RESULTS sectors starting at the open one
      flush_sum    = FLUSH_W'(current_sector_ff) + FLUSH_W'(MAX_RESULTS - 1);
      flush_end_in = (flush_sum > FLUSH_W'(LAST_SECTOR)) ? LAST_SECTOR
                                                           : SECTOR_W'(flush_sum);
   end

   assign item_push  = accept && (scan_end || sector_done);
   assign flush_push = flush_active_ff && (!queue_full || pop);
   assign push       = item_push || flush_push;

   always_comb begin
      if (flush_push) begin
         push_data.sector_index = flush_sector_ff;
         push_data.distance_cm  = empty_cm_ff;
         push_data.last_sector  = (flush_sector_ff == flush_end_ff);
      end else begin
         push_data.sector_index = current_sector_ff;
         push_data.distance_cm  = found_in ? to_cm(minimum_in) : empty_cm_ff;
         push_data.last_sector  = scan_end && (current_sector_ff == LAST_SECTOR);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sample_in_sector_ff <= '0;
         sample_in_scan_ff   <= '0;
         current_sector_ff   <= '0;
         sector_minimum_ff   <= SAMPLE_MASK;
         minimum_found_ff    <= 1'b0;
      end else if (accept) begin
         if (scan_end) begin
            sample_in_sector_ff <= '0;
            sample_in_scan_ff   <= '0;
            current_sector_ff   <= '0;
            sector_minimum_ff   <= SAMPLE_MASK;
            minimum_found_ff    <= 1'b0;
         end else begin
            sample_in_scan_ff <= scan_next[COUNT_W-1:0];
            if (sector_done) begin
               current_sector_ff   <= current_sector_ff + SECTOR_W'(1);
               sample_in_sector_ff <= '0;
               sector_minimum_ff   <= SAMPLE_MASK;
               minimum_found_ff    <= 1'b0;
            end else begin
               // the last sector keeps counting, so hold at the top
               sample_in_sector_ff <= sec_count[COUNT_W] ? '1 : sec_count[COUNT_W-1:0];
               sector_minimum_ff   <= minimum_in;
               minimum_found_ff    <= found_in;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         flush_active_ff <= 1'b0;
         flush_sector_ff <= '0;
         flush_end_ff    <= '0;
      end else if (accept && scan_end && (current_sector_ff != LAST_SECTOR)) begin
         flush_active_ff <= 1'b1;
         flush_sector_ff <= current_sector_ff + SECTOR_W'(1);
         flush_end_ff    <= flush_end_in;
      end else if (flush_push) begin
         if (flush_sector_ff == flush_end_ff) begin
            flush_active_ff <= 1'b0;
         end else begin
            flush_sector_ff <= flush_sector_ff + SECTOR_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
         case ({push, pop})
            2'b10:   count_ff <= count_ff + 2'd1;
            2'b01:   count_ff <= count_ff - 2'd1;
            default: count_ff <= count_ff;
         endcase
      end
   end

   assign rsp_ch.valid        = (count_ff != 2'd0);
   assign rsp_ch.sector_index = queue_ff[rd_ptr_ff].sector_index;
   assign rsp_ch.distance_cm  = queue_ff[rd_ptr_ff].distance_cm;
   assign rsp_ch.last_sector  = queue_ff[rd_ptr_ff].last_sector;

`ifndef ASSERT_OFF
   a_queue_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (!queue_full || pop))
      else $error("result queue written while full");

   a_queue_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff != 2'd3)
      else $error("result queue count out of range");

   a_scan_end_clears: assert property (@(posedge clock) disable iff (reset)
      (accept && scan_end) |=> (sample_in_scan_ff == '0) && (current_sector_ff == '0) &&
                               !minimum_found_ff)
      else $error("scan state not cleared after scan end");

   a_flush_bounds: assert property (@(posedge clock) disable iff (reset)
      flush_active_ff |-> (flush_sector_ff <= flush_end_ff) && (flush_end_ff <= LAST_SECTOR))
      else $error("flush sector outside its range");
`endif

endmodule
